@@ rtl/eic_pkg.sv @@
// ----------------------------------------------------------------------------
// eic_pkg
// Shared types and constants for the ellipse inlier counter.
// ----------------------------------------------------------------------------
package eic_pkg;

    // Control sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FOC_LA,
        S_FOC_SA,
        S_FOC_WAIT,
        S_MUL_X,
        S_MUL_Y,
        S_FOC_SET,
        S_SQ_X,
        S_SQ_Y,
        S_ROOT,
        S_FIN
    } t_state;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_CENTER_X   = 3'd0,
        REG_CENTER_Y   = 3'd1,
        REG_LONG_AXIS  = 3'd2,
        REG_SHORT_AXIS = 3'd3,
        REG_TILT_ANGLE = 3'd4,
        REG_THRESHOLD  = 3'd5
    } t_reg_idx;

    localparam int SQ_W      = 38;          // square root radicand width
    localparam int RT_W      = SQ_W / 2;    // root width
    localparam int CR_W      = 34;          // CORDIC x/y width, Q2.30 plus guard
    localparam int CZ_W      = 24;          // CORDIC angle width, 2^-15 degree
    localparam int CR_STEPS  = 16;
    localparam int FOC_W     = 18;          // focus coordinate width
    localparam int CNT_W     = 17;
    localparam int CNT17_MAX = 131071;

    localparam logic signed [CR_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [16:0]     DEG90       = 17'sd11520;
    localparam logic signed [16:0]     DEG180      = 17'sd23040;

    // atan(2^-i) in units of 2^-15 degree
    function automatic logic signed [CZ_W-1:0] atan_lut(input logic [3:0] i);
        logic signed [CZ_W-1:0] v;
        case (i)
            4'd0:  v = 24'sd1474560;
            4'd1:  v = 24'sd870484;
            4'd2:  v = 24'sd459940;
            4'd3:  v = 24'sd233473;
            4'd4:  v = 24'sd117189;
            4'd5:  v = 24'sd58652;
            4'd6:  v = 24'sd29333;
            4'd7:  v = 24'sd14667;
            4'd8:  v = 24'sd7334;
            4'd9:  v = 24'sd3667;
            4'd10: v = 24'sd1833;
            4'd11: v = 24'sd917;
            4'd12: v = 24'sd458;
            4'd13: v = 24'sd229;
            4'd14: v = 24'sd115;
            4'd15: v = 24'sd57;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/ellipse_inlier_counter_unit.sv @@
// Throughput: one request at a time; two 19-step bit-serial square roots on
//   one shared unit set the rate. The first request of a set also runs
//   a 19-step root and a 16-step CORDIC in parallel to place the foci.
// Reset: synchronous, active low; clears registers, foci, count and state.
// ----------------------------------------------------------------------------
// ellipse_inlier_counter_unit
// Tests points against a configured ellipse by the sum of focal distances
// and keeps a running inlier count per set.
// ----------------------------------------------------------------------------
module ellipse_inlier_counter_unit
    import eic_pkg::*;
#(
    parameter int MAX_POINTS = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    // point requests
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_point_x,
    input  logic signed [15:0] i_point_y,
    input  logic [15:0]        i_point_index,
    input  logic               i_last_point,
    // results
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_is_inlier,
    output logic [15:0]        o_fit_error,
    output logic [15:0]        o_echoed_index,
    output logic [CNT_W-1:0]   o_inlier_count,
    output logic               o_run_end
);

    localparam int CAP = (MAX_POINTS < CNT17_MAX) ? MAX_POINTS : CNT17_MAX;

    // ---------------- configuration registers ----------------
    logic signed [15:0] r_cx, r_cy, r_tilt;
    logic [15:0]        r_la, r_sa, r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= '0;
            r_cy   <= '0;
            r_la   <= '0;
            r_sa   <= '0;
            r_tilt <= '0;
            r_thr  <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_index))
                REG_CENTER_X:   r_cx   <= i_cfg_data;
                REG_CENTER_Y:   r_cy   <= i_cfg_data;
                REG_LONG_AXIS:  r_la   <= i_cfg_data;
                REG_SHORT_AXIS: r_sa   <= i_cfg_data;
                REG_TILT_ANGLE: r_tilt <= i_cfg_data;
                REG_THRESHOLD:  r_thr  <= i_cfg_data;
                default: ;   // unused indexes are dropped
            endcase
        end
    end

    // ---------------- state ----------------
    t_state r_state, n_state;

    logic signed [FOC_W-1:0] r_f1x, r_f1y, r_f2x, r_f2y;
    logic                    r_foci_ok;   // foci valid for the current set
    logic [CNT_W-1:0]        r_count;
    logic                    r_sel;       // 0: first focus, 1: second
    logic signed [15:0]      r_px, r_py;
    logic [15:0]             r_idx;
    logic                    r_last;
    logic [35:0]             r_sq;        // first square of a pair
    logic [15:0]             r_c;         // focal offset length
    logic signed [50:0]      r_prod;
    logic signed [20:0]      r_dx;
    logic [RT_W-1:0]         r_d1;

    // result register
    logic                    r_out_valid;
    logic                    r_out_inl;
    logic [15:0]             r_out_err;
    logic [15:0]             r_out_idx;
    logic [CNT_W-1:0]        r_out_cnt;
    logic                    r_out_end;

    // ---------------- shared units ----------------
    logic                   w_sq_start;
    logic [SQ_W-1:0]        w_sq_in;
    logic                   w_sq_busy;
    logic [RT_W-1:0]        w_root;
    logic                   w_cr_start;
    logic                   w_cr_busy;
    logic signed [CR_W-1:0] w_cos, w_sin;

    eic_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sq_start),
        .i_radicand (w_sq_in),
        .o_busy     (w_sq_busy),
        .o_root     (w_root)
    );

    eic_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cr_start),
        .i_angle (r_tilt),
        .o_busy  (w_cr_busy),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // ---------------- datapath helpers ----------------
    logic                    w_in_acc;
    logic                    w_out_load;
    logic signed [FOC_W-1:0] w_fx, w_fy;
    logic signed [18:0]      w_ex, w_ey;
    logic [17:0]             w_ux, w_uy;
    logic [17:0]             w_mul_a;
    logic [35:0]             w_square;
    logic signed [CR_W-1:0]  w_trig;
    logic signed [50:0]      w_prod;
    logic signed [50:0]      w_rnd;
    logic signed [20:0]      w_dy;
    logic [19:0]             w_sum, w_twice, w_err;
    logic                    w_inl;
    logic [CNT_W-1:0]        w_cnt_next;

    assign w_in_acc = i_valid && o_ready;

    // point minus selected focus; |difference| stays below 2^18
    assign w_fx = r_sel ? r_f2x : r_f1x;
    assign w_fy = r_sel ? r_f2y : r_f1y;
    assign w_ex = 19'(r_px) - 19'(w_fx);
    assign w_ey = 19'(r_py) - 19'(w_fy);
    assign w_ux = w_ex[18] ? 18'(-w_ex) : w_ex[17:0];
    assign w_uy = w_ey[18] ? 18'(-w_ey) : w_ey[17:0];

    // one squarer serves the axes and the distance terms
    always_comb begin
        case (r_state)
            S_FOC_LA: w_mul_a = 18'(r_la);
            S_FOC_SA: w_mul_a = 18'(r_sa);
            S_SQ_X:   w_mul_a = w_ux;
            default:  w_mul_a = w_uy;
        endcase
    end
    assign w_square = w_mul_a * w_mul_a;

    // square root operand: c^2 (clamped at zero) or the distance squared
    always_comb begin
        if (r_state == S_FOC_SA) begin
            w_sq_in = (r_sq > w_square) ? SQ_W'(r_sq - w_square) : '0;
        end else begin
            w_sq_in = SQ_W'(r_sq) + SQ_W'(w_square);
        end
    end

    // offset = round(c * trig) in Q2.30, floor shift
    assign w_trig = (r_state == S_MUL_X) ? w_cos : w_sin;
    assign w_prod = 51'($signed({1'b0, r_c})) * 51'(w_trig);
    assign w_rnd  = r_prod + (51'sd1 <<< 29);
    assign w_dy   = w_rnd[50:30];

    function automatic logic signed [FOC_W-1:0] sat_foc(input logic signed [21:0] v);
        if (v > 22'sd131071) begin
            return 18'sd131071;
        end else if (v < -22'sd131072) begin
            return -18'sd131072;
        end
        return v[FOC_W-1:0];
    endfunction

    // focal sum error against twice the long axis
    assign w_sum   = 20'(r_d1) + 20'(w_root);
    assign w_twice = {3'b0, r_la, 1'b0};
    assign w_err   = (w_sum >= w_twice) ? (w_sum - w_twice) : (w_twice - w_sum);
    assign w_inl   = (w_err < 20'(r_thr));
    assign w_cnt_next = (w_inl && (r_count < CNT_W'(CAP))) ? (r_count + 1'b1) : r_count;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = r_foci_ok ? S_SQ_X : S_FOC_LA;
                end
            end
            S_FOC_LA:   n_state = S_FOC_SA;
            S_FOC_SA:   n_state = S_FOC_WAIT;
            S_FOC_WAIT: begin
                if (!w_sq_busy && !w_cr_busy) begin
                    n_state = S_MUL_X;
                end
            end
            S_MUL_X:    n_state = S_MUL_Y;
            S_MUL_Y:    n_state = S_FOC_SET;
            S_FOC_SET:  n_state = S_SQ_X;
            S_SQ_X:     n_state = S_SQ_Y;
            S_SQ_Y:     n_state = S_ROOT;
            S_ROOT: begin
                if (!w_sq_busy) begin
                    n_state = r_sel ? S_FIN : S_SQ_X;
                end
            end
            S_FIN: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        o_ready    = 1'b0;
        w_sq_start = 1'b0;
        w_cr_start = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            S_IDLE:   o_ready    = 1'b1;
            S_FOC_SA: begin
                w_sq_start = 1'b1;
                w_cr_start = 1'b1;
            end
            S_SQ_Y:   w_sq_start = 1'b1;
            S_FIN:    w_out_load = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_foci_ok   <= 1'b0;
            r_count     <= '0;
            r_sel       <= 1'b0;
            r_f1x       <= '0;
            r_f1y       <= '0;
            r_f2x       <= '0;
            r_f2y       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_sel <= 1'b0;
            end
            if (r_state == S_ROOT && !w_sq_busy) begin
                r_sel <= 1'b1;
            end
            if (r_state == S_FOC_SET) begin
                r_f1x     <= sat_foc(22'(r_cx) - 22'(r_dx));
                r_f1y     <= sat_foc(22'(r_cy) - 22'(w_dy));
                r_f2x     <= sat_foc(22'(r_cx) + 22'(r_dx));
                r_f2y     <= sat_foc(22'(r_cy) + 22'(w_dy));
                r_foci_ok <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                // end of set: clear count, foci rebuilt on next request
                r_count     <= r_last ? '0 : w_cnt_next;
                if (r_last) begin
                    r_foci_ok <= 1'b0;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_px   <= i_point_x;
            r_py   <= i_point_y;
            r_idx  <= i_point_index;
            r_last <= i_last_point;
        end
        if (r_state == S_FOC_LA || r_state == S_SQ_X) begin
            r_sq <= w_square;
        end
        if (r_state == S_FOC_WAIT) begin
            r_c <= w_root[15:0];
        end
        if (r_state == S_MUL_X || r_state == S_MUL_Y) begin
            r_prod <= w_prod;
        end
        if (r_state == S_MUL_Y) begin
            r_dx <= w_rnd[50:30];
        end
        if (r_state == S_ROOT && !w_sq_busy && !r_sel) begin
            r_d1 <= w_root;
        end
        if (w_out_load) begin
            r_out_inl <= w_inl;
            r_out_err <= (|w_err[19:16]) ? 16'hFFFF : w_err[15:0];
            r_out_idx <= r_idx;
            r_out_cnt <= w_cnt_next;
            r_out_end <= r_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_is_inlier    = r_out_inl;
    assign o_fit_error    = r_out_err;
    assign o_echoed_index = r_out_idx;
    assign o_inlier_count = r_out_cnt;
    assign o_run_end      = r_out_end;

    // ---------------- assertions ----------------
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_inlier_count <= CNT_W'(CAP)))
        else $error("inlier count above cap");

    a_inl_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_inlier && (CAP > 0) |-> (o_inlier_count != '0))
        else $error("inlier reported with zero count");

    a_sq_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_start |-> !w_sq_busy)
        else $error("square root restarted while busy");

    a_foci_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOC_LA) |-> !r_foci_ok)
        else $error("foci rebuilt inside a set");

endmodule

@@ rtl/eic_sqrt.sv @@
// ----------------------------------------------------------------------------
// eic_sqrt
// Floor square root, restoring, one result bit (two radicand bits) a cycle.
// ----------------------------------------------------------------------------
module eic_sqrt
    import eic_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_radicand,
    output logic              o_busy,
    output logic [RT_W-1:0]   o_root
);

    localparam int CW = $clog2(RT_W + 1);

    logic [SQ_W-1:0] r_rad;
    logic [RT_W+1:0] r_rem;
    logic [RT_W-1:0] r_root;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;

    logic [RT_W+3:0] w_sh;
    logic [RT_W+3:0] w_trial;
    logic            w_ge;

    assign w_sh    = {r_rem, r_rad[SQ_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = (w_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(RT_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= r_rad << 2;
            if (w_ge) begin
                r_rem  <= (RT_W+2)'(w_sh - w_trial);
                r_root <= {r_root[RT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_sh[RT_W+1:0];
                r_root <= {r_root[RT_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

@@ rtl/eic_cordic.sv @@
// ----------------------------------------------------------------------------
// eic_cordic
// Iterative rotation CORDIC, one micro-rotation a cycle, gives cos and sin.
// ----------------------------------------------------------------------------
module eic_cordic
    import eic_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [15:0]     i_angle,
    output logic                   o_busy,
    output logic signed [CR_W-1:0] o_cos,
    output logic signed [CR_W-1:0] o_sin
);

    logic signed [CR_W-1:0] r_x, r_y;
    logic signed [CZ_W-1:0] r_z;
    logic [3:0]             r_i;
    logic                   r_busy;
    logic                   r_flip;

    logic signed [16:0]     w_a;
    logic signed [16:0]     w_red;
    logic                   w_flip;
    logic signed [CR_W-1:0] w_xs, w_ys;

    // bring the angle into +-90 degrees; one half turn is enough for 16 bits
    always_comb begin
        w_a = 17'(i_angle);
        if (w_a > DEG90) begin
            w_red  = w_a - DEG180;
            w_flip = 1'b1;
        end else if (w_a < -DEG90) begin
            w_red  = w_a + DEG180;
            w_flip = 1'b1;
        end else begin
            w_red  = w_a;
            w_flip = 1'b0;
        end
    end

    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
        end else if (r_busy) begin
            if (r_i == 4'(CR_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
            r_i <= r_i + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= {w_red[15:0], 8'b0};
            r_flip <= w_flip;
        end else if (r_busy) begin
            if (!r_z[CZ_W-1]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - atan_lut(r_i);
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + atan_lut(r_i);
            end
        end
    end

    assign o_busy = r_busy;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

endmodule
